### sv/tea_pkg.sv
// package: item types, command codes, register indexes and sequencer states
`default_nettype none
package tea_pkg;

  typedef enum logic [1:0] {
    CMD_CHAIN_ENC = 2'd0,
    CMD_CHAIN_DEC = 2'd1,
    CMD_RAW_ENC   = 2'd2,
    CMD_RAW_DEC   = 2'd3
  } cmd_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ROUND_W    = 7;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = 3'd5;

  localparam logic [31:0]        DELTA_RESET  = 32'h9E3779B9;
  localparam logic [ROUND_W-1:0] ROUNDS_RESET = 7'd16;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] block_left;
    logic [31:0] block_right;
    logic        first_block;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_left;
    logic [31:0] result_right;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        key_word0;
    logic [31:0]        key_word1;
    logic [31:0]        key_word2;
    logic [31:0]        key_word3;
    logic [31:0]        round_delta;
    logic [ROUND_W-1:0] round_count;
  } tea_cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic decrypt;
  } core_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

### sv/tea_cfg.sv
// configuration register file: key words, round delta and round count
`default_nettype none
module tea_cfg
  import tea_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output tea_cfg_t                   cfg
);

  tea_cfg_t cfg_r;
  tea_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY0:   cfg_nxt.key_word0   = cfg_wdata;
        REG_KEY1:   cfg_nxt.key_word1   = cfg_wdata;
        REG_KEY2:   cfg_nxt.key_word2   = cfg_wdata;
        REG_KEY3:   cfg_nxt.key_word3   = cfg_wdata;
        REG_DELTA:  cfg_nxt.round_delta = cfg_wdata;
        REG_ROUNDS: cfg_nxt.round_count = cfg_wdata[ROUND_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_word0   <= '0;
      cfg_r.key_word1   <= '0;
      cfg_r.key_word2   <= '0;
      cfg_r.key_word3   <= '0;
      cfg_r.round_delta <= DELTA_RESET;
      cfg_r.round_count <= ROUNDS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### sv/tea_core.sv
// shared round unit: one tea double round per step, with running sum
`default_nettype none
module tea_core
  import tea_pkg::*;
(
  input  wire logic        clk,
  input  wire tea_cfg_t    cfg,
  input  wire core_ctrl_t  ctrl,
  input  wire logic [63:0] blk_in,
  output logic      [63:0] blk_out
);

  logic [31:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic        dec_r, dec_nxt;
  logic [31:0] sum_init;
  logic [31:0] enc_a, enc_b, dec_a, dec_b;

  function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] s,
                                          input logic [31:0] ka, input logic [31:0] kb);
    tea_mix = ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
  endfunction

  assign sum_init = cfg.round_delta * {25'd0, cfg.round_count};

  always_comb begin
    enc_a = a_r + tea_mix(b_r, sum_r, cfg.key_word0, cfg.key_word1);
    enc_b = b_r + tea_mix(enc_a, sum_r, cfg.key_word2, cfg.key_word3);
    dec_b = b_r - tea_mix(a_r, sum_r, cfg.key_word2, cfg.key_word3);
    dec_a = a_r - tea_mix(dec_b, sum_r, cfg.key_word0, cfg.key_word1);
  end

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    sum_nxt = sum_r;
    dec_nxt = dec_r;
    if (ctrl.load) begin
      a_nxt   = blk_in[63:32];
      b_nxt   = blk_in[31:0];
      dec_nxt = ctrl.decrypt;
      sum_nxt = ctrl.decrypt ? sum_init : cfg.round_delta;
    end else if (ctrl.step) begin
      if (dec_r) begin
        a_nxt   = dec_a;
        b_nxt   = dec_b;
        sum_nxt = sum_r - cfg.round_delta;
      end else begin
        a_nxt   = enc_a;
        b_nxt   = enc_b;
        sum_nxt = sum_r + cfg.round_delta;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    sum_r <= sum_nxt;
    dec_r <= dec_nxt;
  end

  assign blk_out = {a_r, b_r};

endmodule
`default_nettype wire

### sv/tea_cipher_with_feedback_chain.sv
// top level: sequencer, feedback chain registers and result register
`default_nettype none
// TEA block cipher with a two-register feedback chain. An item is one 64-bit
// block (two big-endian words), a command and a first-block flag; it yields
// one 64-bit block. One shared round unit runs one double round per cycle;
// an item passes through a load, a step for each double round, a check of
// the round counter at zero, and a step that applies the feedback xor and
// loads the result register. in_stall stays high while an item is at work;
// the result register lets the next item enter while the last result still
// waits on out_stall. Configuration must be written only while the block is
// idle; the block itself does not enforce this.
module tea_cipher_with_feedback_chain
  import tea_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  tea_cfg_t   cfg;
  core_ctrl_t ctrl;
  logic [63:0] core_in, core_out;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [63:0]        hold_r, hold_nxt;
  logic [ROUND_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]        cfb_r, cfb_nxt;
  logic [63:0]        pfb_r, pfb_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic [63:0] blk, cfb_eff, pfb_eff, res;

  tea_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tea_core u_core (
    .clk     (clk),
    .cfg     (cfg),
    .ctrl    (ctrl),
    .blk_in  (core_in),
    .blk_out (core_out)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    hold_nxt      = hold_r;
    cnt_nxt       = cnt_r;
    cfb_nxt       = cfb_r;
    pfb_nxt       = pfb_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctrl          = '0;
    core_in       = '0;
    res           = core_out;
    blk           = {in_item.block_left, in_item.block_right};
    cfb_eff       = in_item.first_block ? 64'd0 : cfb_r;
    pfb_eff       = in_item.first_block ? 64'd0 : pfb_r;
    in_stall      = (state_r != ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt    = ST_ROUND;
          cmd_nxt      = in_item.cmd;
          cnt_nxt      = cfg.round_count;
          cfb_nxt      = cfb_eff;
          pfb_nxt      = pfb_eff;
          ctrl.load    = 1'b1;
          ctrl.decrypt = (in_item.cmd == CMD_CHAIN_DEC) || (in_item.cmd == CMD_RAW_DEC);
          hold_nxt     = blk;
          core_in      = blk;
          case (in_item.cmd)
            CMD_CHAIN_ENC: begin
              core_in  = blk ^ cfb_eff;
              hold_nxt = blk ^ cfb_eff;
            end
            CMD_CHAIN_DEC: core_in = blk ^ pfb_eff;
            default:       core_in = blk;
          endcase
        end
      end
      ST_ROUND: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          ctrl.step = 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          case (cmd_r)
            CMD_CHAIN_ENC: begin
              res     = core_out ^ pfb_r;
              cfb_nxt = core_out ^ pfb_r;
              pfb_nxt = hold_r;
            end
            CMD_CHAIN_DEC: begin
              res     = core_out ^ cfb_r;
              pfb_nxt = core_out;
              cfb_nxt = hold_r;
            end
            default: res = core_out;
          endcase
          out_item_nxt.result_left  = res[63:32];
          out_item_nxt.result_right = res[31:0];
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cfb_r       <= '0;
      pfb_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cfb_r       <= cfb_nxt;
      pfb_r       <= pfb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    hold_r     <= hold_nxt;
    cnt_r      <= cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire
